// ===== src/mwo_pkg.sv =====
// Shared constants, codes and table functions for the multi-waveform oscillator.
// Used by mwo_sine_rom and multi_waveform_oscillator; depends on nothing else.
package mwo_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_WAVEFORM   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_GAIN       = 2'd2;

	localparam logic [2:0] WAVE_SINE     = 3'd0;
	localparam logic [2:0] WAVE_SQUARE   = 3'd1;
	localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
	localparam logic [2:0] WAVE_SAW      = 3'd3;
	localparam logic [2:0] WAVE_FAST_SAW = 3'd4;
	localparam logic [2:0] WAVE_NOISE    = 3'd5;

	localparam logic [2:0]  WAVEFORM_RESET   = WAVE_SAW;
	localparam logic [31:0] PHASE_STEP_RESET = 32'd42852281;
	localparam logic [14:0] GAIN_RESET       = 15'd328;
	localparam logic [31:0] LFSR_SEED        = 32'd1;
	localparam logic [31:0] LFSR_TAPS        = 32'hD000_0001;

	localparam int SINE_W = 15;
	localparam logic [16:0] TWO_OVER_PI_Q16 = 17'd41722;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	// Harmonic weights round(65536 / n), indexed by harmonic number.
	localparam logic [16:0] HARM_WEIGHT [64] = '{
		17'd0,     17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10923, 17'd9362,
		17'd8192,  17'd7282,  17'd6554,  17'd5958,  17'd5461,  17'd5041,  17'd4681,  17'd4369,
		17'd4096,  17'd3855,  17'd3641,  17'd3449,  17'd3277,  17'd3121,  17'd2979,  17'd2849,
		17'd2731,  17'd2621,  17'd2521,  17'd2427,  17'd2341,  17'd2260,  17'd2185,  17'd2114,
		17'd2048,  17'd1986,  17'd1928,  17'd1872,  17'd1820,  17'd1771,  17'd1725,  17'd1680,
		17'd1638,  17'd1598,  17'd1560,  17'd1524,  17'd1489,  17'd1456,  17'd1425,  17'd1394,
		17'd1365,  17'd1337,  17'd1311,  17'd1285,  17'd1260,  17'd1237,  17'd1214,  17'd1192,
		17'd1170,  17'd1150,  17'd1130,  17'd1111,  17'd1092,  17'd1074,  17'd1057,  17'd1040
	};

	// One quarter-wave entry: Taylor series to the x^13 term in Q30, then scaled to Q15.
	function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx,
		input int unsigned tab_bits);
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint e;
		x = (HALF_PI_Q30 * longint'(idx)) >>> tab_bits;
		x2 = (x * x) >>> 30;
		term = x;
		sum = x;
		term = ((term * x2) >>> 30) / 6;
		sum = sum - term;
		term = ((term * x2) >>> 30) / 20;
		sum = sum + term;
		term = ((term * x2) >>> 30) / 42;
		sum = sum - term;
		term = ((term * x2) >>> 30) / 72;
		sum = sum + term;
		term = ((term * x2) >>> 30) / 110;
		sum = sum - term;
		term = ((term * x2) >>> 30) / 156;
		sum = sum + term;
		if (sum < 0) begin
			sum = 0;
		end
		e = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
		if (e > 32767) begin
			e = 32767;
		end
		return SINE_W'(e);
	endfunction

endpackage

// ===== src/mwo_sine_rom.sv =====
// Quarter-wave sine ROM with registered read data.
// Contents are built at elaboration with mwo_pkg::sine_entry.
module mwo_sine_rom #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                         clk,
	input  logic [SINE_TABLE_BITS:0]     addr,
	output logic [mwo_pkg::SINE_W-1:0]   data_q
);

	localparam int QSIZE = 1 << SINE_TABLE_BITS;

	typedef logic [mwo_pkg::SINE_W-1:0] rom_t [QSIZE+1];

	function automatic rom_t build_rom();
		rom_t t;
		for (int i = 0; i <= QSIZE; i++) begin
			t[i] = mwo_pkg::sine_entry(i, SINE_TABLE_BITS);
		end
		return t;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	always_ff @(posedge clk) begin
		data_q <= SINE_ROM[addr];
	end

endmodule

// ===== src/multi_waveform_oscillator.sv =====
// Top level of the multi-waveform oscillator: handshakes, configuration, sequencer
// and the shared multiplier. Depends on mwo_pkg and mwo_sine_rom.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    sample_index
// out       output     out_valid / out_stall  sample, clipped
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// From acceptance to the next possible acceptance a word passes PH_LO, PH_HI, PH_SUM,
// WAVE, SAT, GAIN and RND; sine and square add SINE_RD, additive saw HARM and SAW_*.
// All products go through one 33 by 18 bit multiplier; the saw harmonics stream
// through it one per cycle behind the sine ROM read port.
// in_stall is high from acceptance until the result is loaded into the output register;
// a result that finds the previous word still stalled waits in the last state.
// Reset sets the registers to their defaults and the noise generator to its seed.
module multi_waveform_oscillator #(
	parameter int SINE_TABLE_BITS = 10,
	parameter int HARMONICS = 49
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [31:0]                          sample_index,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [15:0]                   sample,
	output logic                                 clipped,
	input  logic                                 cfg_we,
	input  logic [mwo_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [mwo_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int ADDR_W = SINE_TABLE_BITS + 1;
	localparam int N_W = $clog2(HARMONICS + 2);
	localparam int ACC_W = 36;
	localparam int BIG_W = 52;
	localparam int V_W = 20;
	localparam int P_W = 51;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PH_LO, ST_PH_HI, ST_PH_SUM, ST_WAVE, ST_SINE_RD, ST_HARM,
		ST_SAW_LO, ST_SAW_HI, ST_SAW_ADD, ST_SAW_RND, ST_SAT, ST_GAIN, ST_RND
	} state_t;

	state_t state_q;

	logic [2:0]  waveform_q;
	logic [31:0] phase_step_q;
	logic [14:0] gain_q;
	logic [31:0] lfsr_q;

	logic [31:0] idx_q;
	logic [31:0] phase_q;
	logic [31:0] pn_q;
	logic [N_W-1:0] n_q;
	logic [5:0] n_s1;
	logic valid_s1;
	logic valid_s2;
	logic neg_s1;
	logic signed [P_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [BIG_W-1:0] big_q;
	logic signed [V_W-1:0] v_q;
	logic signed [15:0] vs_q;
	logic clip_q;
	logic signed [15:0] sample_q;
	logic clipped_q;
	logic out_valid_q;

	logic [SINE_TABLE_BITS-1:0] rom_k;
	logic [ADDR_W-1:0] rom_addr;
	logic [mwo_pkg::SINE_W-1:0] rom_q;
	logic signed [16:0] sine_s1;
	logic signed [32:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [P_W-1:0] mul_p;
	logic issue;
	logic [31:0] lfsr_next;
	logic signed [V_W-1:0] tri_a;
	logic signed [BIG_W-1:0] big_rnd;
	logic signed [P_W-1:0] gain_rnd;

	assign rom_k = pn_q[29 -: SINE_TABLE_BITS];
	assign rom_addr = pn_q[30] ? (ADDR_W'(1 << SINE_TABLE_BITS) - {1'b0, rom_k})
		: {1'b0, rom_k};

	mwo_sine_rom #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_rom (
		.clk(clk),
		.addr(rom_addr),
		.data_q(rom_q)
	);

	assign sine_s1 = neg_s1 ? -$signed({2'b00, rom_q}) : $signed({2'b00, rom_q});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_PH_LO: begin
				mul_a = $signed({1'b0, phase_step_q});
				mul_b = $signed({2'b00, idx_q[15:0]});
			end
			ST_PH_HI: begin
				mul_a = $signed({1'b0, phase_step_q});
				mul_b = $signed({2'b00, idx_q[31:16]});
			end
			ST_HARM: begin
				mul_a = 33'(sine_s1);
				mul_b = $signed({1'b0, mwo_pkg::HARM_WEIGHT[n_s1]});
			end
			ST_SAW_LO: begin
				mul_a = $signed({15'd0, acc_q[17:0]});
				mul_b = $signed({1'b0, mwo_pkg::TWO_OVER_PI_Q16});
			end
			ST_SAW_HI: begin
				mul_a = 33'($signed(acc_q[ACC_W-1:18]));
				mul_b = $signed({1'b0, mwo_pkg::TWO_OVER_PI_Q16});
			end
			ST_GAIN, ST_RND: begin
				mul_a = 33'(vs_q);
				mul_b = $signed({3'b000, gain_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign issue = (n_q <= N_W'(HARMONICS));
	assign lfsr_next = (lfsr_q >> 1) ^ (lfsr_q[0] ? mwo_pkg::LFSR_TAPS : 32'd0);
	assign tri_a = $signed({3'b000, phase_q[31:15]});
	assign big_rnd = big_q + (big_q[BIG_W-1] ? BIG_W'(64'sd2147483647)
		: BIG_W'(64'sd2147483648));
	assign gain_rnd = prod_q + (prod_q[P_W-1] ? P_W'(64'sd16383) : P_W'(64'sd16384));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			waveform_q <= mwo_pkg::WAVEFORM_RESET;
			phase_step_q <= mwo_pkg::PHASE_STEP_RESET;
			gain_q <= mwo_pkg::GAIN_RESET;
			lfsr_q <= mwo_pkg::LFSR_SEED;
			idx_q <= '0;
			phase_q <= '0;
			pn_q <= '0;
			n_q <= '0;
			n_s1 <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			neg_s1 <= 1'b0;
			prod_q <= '0;
			acc_q <= '0;
			big_q <= '0;
			v_q <= '0;
			vs_q <= '0;
			clip_q <= 1'b0;
			sample_q <= '0;
			clipped_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mwo_pkg::CFG_WAVEFORM:   waveform_q <= cfg_data[2:0];
					mwo_pkg::CFG_PHASE_STEP: phase_step_q <= cfg_data[31:0];
					mwo_pkg::CFG_GAIN:       gain_q <= cfg_data[14:0];
					default: ;
				endcase
			end

			prod_q <= mul_p;
			neg_s1 <= pn_q[31];

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q <= sample_index;
						state_q <= ST_PH_LO;
					end
				end
				ST_PH_LO: begin
					state_q <= ST_PH_HI;
				end
				ST_PH_HI: begin
					phase_q <= prod_q[31:0];
					state_q <= ST_PH_SUM;
				end
				ST_PH_SUM: begin
					phase_q <= phase_q + {prod_q[15:0], 16'd0};
					pn_q <= phase_q + {prod_q[15:0], 16'd0};
					state_q <= ST_WAVE;
				end
				ST_WAVE: begin
					state_q <= ST_SAT;
					case (waveform_q)
						mwo_pkg::WAVE_SINE, mwo_pkg::WAVE_SQUARE: begin
							state_q <= ST_SINE_RD;
						end
						mwo_pkg::WAVE_TRIANGLE: begin
							if (tri_a < 20'sd32768) begin
								v_q <= tri_a;
							end else if (tri_a < 20'sd98304) begin
								v_q <= 20'sd65536 - tri_a;
							end else begin
								v_q <= tri_a - 20'sd131072;
							end
						end
						mwo_pkg::WAVE_SAW: begin
							n_q <= N_W'(1);
							acc_q <= '0;
							valid_s1 <= 1'b0;
							valid_s2 <= 1'b0;
							state_q <= ST_HARM;
						end
						mwo_pkg::WAVE_FAST_SAW: begin
							v_q <= $signed({4'd0, phase_q[31:16]}) - 20'sd32768;
						end
						mwo_pkg::WAVE_NOISE: begin
							lfsr_q <= lfsr_next;
							v_q <= $signed({4'd0, lfsr_next[31:16]}) - 20'sd32768;
						end
						default: begin
							v_q <= '0;
						end
					endcase
				end
				ST_SINE_RD: begin
					if (waveform_q == mwo_pkg::WAVE_SQUARE) begin
						v_q <= (!neg_s1 && rom_q != '0) ? 20'sd32767 : -20'sd32767;
					end else begin
						v_q <= V_W'(sine_s1);
					end
					state_q <= ST_SAT;
				end
				ST_HARM: begin
					if (issue) begin
						pn_q <= pn_q + phase_q;
						n_q <= n_q + N_W'(1);
					end
					valid_s1 <= issue;
					n_s1 <= 6'(n_q);
					valid_s2 <= valid_s1;
					if (valid_s2) begin
						acc_q <= acc_q + ACC_W'(prod_q);
					end
					if (!issue && !valid_s1 && !valid_s2) begin
						state_q <= ST_SAW_LO;
					end
				end
				ST_SAW_LO: begin
					state_q <= ST_SAW_HI;
				end
				ST_SAW_HI: begin
					big_q <= BIG_W'(prod_q);
					state_q <= ST_SAW_ADD;
				end
				ST_SAW_ADD: begin
					big_q <= big_q + (BIG_W'(prod_q) <<< 18);
					state_q <= ST_SAW_RND;
				end
				ST_SAW_RND: begin
					v_q <= $signed(big_rnd[BIG_W-1:32]);
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					if (v_q > 20'sd32767) begin
						vs_q <= 16'sd32767;
						clip_q <= 1'b1;
					end else if (v_q < -20'sd32768) begin
						vs_q <= -16'sd32768;
						clip_q <= 1'b1;
					end else begin
						vs_q <= 16'(v_q);
						clip_q <= 1'b0;
					end
					state_q <= ST_GAIN;
				end
				ST_GAIN: begin
					state_q <= ST_RND;
				end
				ST_RND: begin
					if (!out_valid_q || !out_stall) begin
						sample_q <= $signed(gain_rnd[30:15]);
						clipped_q <= clip_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign sample = sample_q;
	assign clipped = clipped_q;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for multi_waveform_oscillator: directed and random words
// checked against a predictor kept in a small scoreboard class.
// Depends on mwo_pkg and the multi_waveform_oscillator RTL.
module tb_top;

	localparam int TAB_BITS = 10;
	localparam int TAB_Q = 1 << TAB_BITS;
	localparam int NUM_HARM = 49;
	localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
	localparam longint SAW_SCALE_Q16 = 64'sd41722;
	localparam logic [31:0] NOISE_TAPS = 32'hD000_0001;
	localparam logic [31:0] NOISE_SEED = 32'd1;
	localparam logic [31:0] STEP_AT_RESET = 32'd42852281;
	localparam logic [14:0] GAIN_AT_RESET = 15'd328;
	localparam logic [14:0] GAIN_FULL = 15'h7FFF;
	localparam logic [mwo_pkg::CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
	localparam int WORDS_TARGET = 2000;
	localparam int IDLE_LIMIT = 5000;
	localparam int TAIL_CYCLES = 100;

	class osc_scoreboard;
		typedef struct {
			logic signed [15:0] sample;
			logic clipped;
		} osc_word_t;

		int quarter_sine[TAB_Q + 1];
		logic [2:0] wave;
		logic [31:0] step;
		logic [14:0] gain;
		logic [31:0] lfsr;
		osc_word_t samples_due[$];
		int errors;
		int words_checked;

		function new();
			longint x;
			longint x2;
			longint term;
			longint sum;
			longint e;
			for (int i = 0; i <= TAB_Q; i++) begin
				x = (QUARTER_TURN_Q30 * i) / TAB_Q;
				x2 = (x * x) >>> 30;
				term = x;
				sum = x;
				for (int k = 1; k <= 6; k++) begin
					term = ((term * x2) >>> 30) / (2 * k * (2 * k + 1));
					sum = (k % 2 == 1) ? sum - term : sum + term;
				end
				if (sum < 0) begin
					sum = 0;
				end
				e = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
				if (e > 32767) begin
					e = 32767;
				end
				quarter_sine[i] = int'(e);
			end
			wave = mwo_pkg::WAVE_SAW;
			step = STEP_AT_RESET;
			gain = GAIN_AT_RESET;
			lfsr = NOISE_SEED;
			errors = 0;
			words_checked = 0;
		endfunction

		function int table_sine(logic [31:0] ph);
			int k;
			k = int'((ph >> (30 - TAB_BITS)) & (TAB_Q - 1));
			case (ph[31:30])
				2'd0: return quarter_sine[k];
				2'd1: return quarter_sine[TAB_Q - k];
				2'd2: return -quarter_sine[k];
				default: return -quarter_sine[TAB_Q - k];
			endcase
		endfunction

		function longint round_away(longint v, int sh);
			longint m;
			m = (v < 0) ? -v : v;
			m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
			return (v < 0) ? -m : m;
		endfunction

		function longint wave_value(logic [31:0] ph);
			longint a;
			longint acc;
			logic [31:0] ph_n;
			case (wave)
				mwo_pkg::WAVE_SINE: return table_sine(ph);
				mwo_pkg::WAVE_SQUARE: return (table_sine(ph) > 0) ? 32767 : -32767;
				mwo_pkg::WAVE_TRIANGLE: begin
					a = ph[31:15];
					if (a < 32768) begin
						return a;
					end else if (a < 98304) begin
						return 65536 - a;
					end
					return a - 131072;
				end
				mwo_pkg::WAVE_SAW: begin
					acc = 0;
					for (int n = 1; n <= NUM_HARM; n++) begin
						ph_n = ph * 32'(n);
						acc += longint'(table_sine(ph_n)) * ((65536 + n / 2) / n);
					end
					return round_away(acc * SAW_SCALE_Q16, 32);
				end
				mwo_pkg::WAVE_FAST_SAW: return longint'(ph[31:16]) - 32768;
				mwo_pkg::WAVE_NOISE: begin
					lfsr = lfsr[0] ? ((lfsr >> 1) ^ NOISE_TAPS) : (lfsr >> 1);
					return longint'(lfsr[31:16]) - 32768;
				end
				default: return 0;
			endcase
		endfunction

		function void write_reg(logic [mwo_pkg::CFG_INDEX_W-1:0] idx,
			logic [mwo_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				mwo_pkg::CFG_WAVEFORM: wave = data[2:0];
				mwo_pkg::CFG_PHASE_STEP: step = data;
				mwo_pkg::CFG_GAIN: gain = data[14:0];
				default: ;
			endcase
		endfunction

		function void note_word(logic [31:0] idx);
			logic [31:0] ph;
			longint v;
			longint s;
			osc_word_t w;
			ph = idx * step;
			v = wave_value(ph);
			w.clipped = 1'b0;
			if (v > 32767) begin
				v = 32767;
				w.clipped = 1'b1;
			end else if (v < -32768) begin
				v = -32768;
				w.clipped = 1'b1;
			end
			s = round_away(v * longint'(gain), 15);
			w.sample = s[15:0];
			samples_due.push_back(w);
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_word(logic signed [15:0] s, logic c);
			osc_word_t w;
			if (samples_due.size() == 0) begin
				report($sformatf("word with no expectation, sample %0d clipped %0b", s, c));
				return;
			end
			w = samples_due.pop_front();
			words_checked++;
			if (s !== w.sample) begin
				report($sformatf("word %0d sample %0d, expected %0d", words_checked, s,
					w.sample));
			end
			if (c !== w.clipped) begin
				report($sformatf("word %0d clipped %0b, expected %0b", words_checked, c,
					w.clipped));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] sample_index = 32'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] sample;
	logic clipped;
	logic cfg_we = 1'b0;
	logic [mwo_pkg::CFG_INDEX_W-1:0] cfg_index = mwo_pkg::CFG_WAVEFORM;
	logic [mwo_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	osc_scoreboard sb = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	int idle_cycles = 0;
	int settings_used = 0;

	multi_waveform_oscillator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_index(sample_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample(sample),
		.clipped(clipped),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_word(sample, clipped);
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task send_word(logic [31:0] idx);
		in_valid <= 1'b1;
		sample_index <= idx;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_word(idx);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			sample_index <= $urandom;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task drain();
		in_valid <= 1'b0;
		while (sb.samples_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task write_reg(logic [mwo_pkg::CFG_INDEX_W-1:0] idx, logic [mwo_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Unused upper bits carry random junk so the register masking is exercised.
	task configure(logic [2:0] w, logic [31:0] st, logic [14:0] g);
		drain();
		write_reg(mwo_pkg::CFG_WAVEFORM, ($urandom & 32'hFFFF_FFF8) | 32'(w));
		write_reg(mwo_pkg::CFG_PHASE_STEP, st);
		write_reg(mwo_pkg::CFG_GAIN, ($urandom & 32'hFFFF_8000) | 32'(g));
		write_reg(CFG_SPARE, $urandom);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		logic [31:0] idx;
		logic [31:0] st;
		logic [14:0] g;
		int phase;
		int words;
		int run_len;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(32'd0);
		send_word(32'hFFFF_FFFF);
		send_word(32'd1);
		for (int w = 0; w <= 7; w++) begin
			configure(3'(w), 32'd1, GAIN_FULL);
			send_word(32'h4000_0000);
			send_word(32'hFFFF_FFFF);
		end

		phase = 0;
		words = 0;
		while (words < WORDS_TARGET) begin
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 55;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 55;
				end
				default: begin
					send_idle_pct = 23;
					stall_pct = 23;
				end
			endcase
			case ($urandom_range(5))
				0: st = 32'd0;
				1: st = 32'hFFFF_FFFF;
				2: st = $urandom_range(1, 1 << 20);
				default: st = $urandom;
			endcase
			case ($urandom_range(3))
				0: g = 15'd0;
				1: g = GAIN_FULL;
				default: g = 15'($urandom);
			endcase
			configure(3'($urandom_range(7)), st, g);
			run_len = $urandom_range(20, 60);
			idx = $urandom;
			repeat (run_len) begin
				case ($urandom_range(9))
					0: idx = $urandom;
					1: idx = $urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF;
					default: idx = idx + 32'd1;
				endcase
				send_word(idx);
				words++;
			end
			phase++;
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d words over %0d register settings, all eight waveform codes,",
			sb.words_checked, settings_used);
		$display("masked register writes and mixed idle and stall patterns on both channels.");
		if (sb.errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end
endmodule
